// ----- rtl/mfd_pkg.sv -----
// Shared types, constants and byte functions for the meter frame decoder.
// Used by mfd_frame_core and the top level; depends on nothing.
package mfd_pkg;

  localparam int unsigned FRAME_BYTES = 22;

  localparam logic [7:0]  LEN_EXPECTED = 8'h13;
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [31:0] ID_XOR       = 32'h3000_0000;

  localparam logic [4:0] POS_LAST_PAYLOAD = 5'd19;
  localparam logic [4:0] POS_CRC_HI       = 5'd20;
  localparam logic [4:0] POS_END          = 5'(FRAME_BYTES);

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_LEN = 2'd1,
    STATUS_CRC = 2'd2
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] frame_byte;
    logic       frame_start;
  } beat_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] device_id;
    logic [24:0] volume_liters;
    logic [6:0]  year_offset;
    logic [3:0]  month_field;
    logic [4:0]  day_field;
  } result_t;

  localparam logic [3:0] NIB_SUB [16] = '{
    4'h0, 4'h7, 4'hf, 4'h9, 4'he, 4'hd, 4'h3, 4'h4,
    4'h2, 4'h6, 4'hc, 4'hb, 4'h1, 4'h8, 4'ha, 4'h5
  };

  function automatic logic [7:0] whiten_key(input logic [4:0] pos);
    logic [7:0] k;
    case (pos)
      5'd0:    k = 8'hff;
      5'd1:    k = 8'he1;
      5'd2:    k = 8'h1d;
      5'd3:    k = 8'h9a;
      5'd4:    k = 8'hed;
      5'd5:    k = 8'h85;
      5'd6:    k = 8'h33;
      5'd7:    k = 8'h24;
      5'd8:    k = 8'hea;
      5'd9:    k = 8'h7a;
      5'd10:   k = 8'hd2;
      5'd11:   k = 8'h39;
      5'd12:   k = 8'h70;
      5'd13:   k = 8'h97;
      5'd14:   k = 8'h57;
      5'd15:   k = 8'h0a;
      5'd16:   k = 8'h54;
      5'd17:   k = 8'h7d;
      5'd18:   k = 8'h2d;
      5'd19:   k = 8'hd8;
      5'd20:   k = 8'h6d;
      5'd21:   k = 8'h0d;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

  // MSB-first, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] decode_byte(input logic [7:0] d);
    return {NIB_SUB[d[7:4]], NIB_SUB[d[3:0]]};
  endfunction

endpackage

// ----- rtl/mfd_in_if.sv -----
// Input channel: one whitened frame byte per beat.
// No dependencies.
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ----- rtl/mfd_out_if.sv -----
// Output channel: one decoded frame result per beat.
// No dependencies.
interface mfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] device_id;
  logic [24:0] volume_liters;
  logic [6:0]  year_offset;
  logic [3:0]  month_field;
  logic [4:0]  day_field;

  modport source (output valid, output status, output device_id, output volume_liters,
                  output year_offset, output month_field, output day_field, input ready);
  modport sink   (input valid, input status, input device_id, input volume_liters,
                  input year_offset, input month_field, input day_field, output ready);
endinterface

// ----- rtl/mfd_frame_core.sv -----
// Frame state, dewhitening, CRC and field extraction for one byte beat.
// Depends on mfd_pkg.
module mfd_frame_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mfd_pkg::beat_t  beat_i,
  input  logic            en_i,
  output logic            res_valid_o,
  output mfd_pkg::result_t res_o
);

  logic [4:0]  pos_q, pos_d;
  logic        in_frame_q, in_frame_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [31:0] id_q, id_d;
  logic [27:0] vol_q, vol_d;
  logic [7:0]  date_lo_q, date_lo_d;
  logic [7:0]  date_hi_q, date_hi_d;

  logic [7:0]  d_byte;
  logic [7:0]  p_byte;
  logic [15:0] crc_next;
  logic [15:0] date_w;

  always_comb begin
    d_byte   = beat_i.frame_byte ^
               mfd_pkg::whiten_key(beat_i.frame_start ? 5'd0 : pos_q);
    p_byte   = mfd_pkg::decode_byte(d_byte);
    crc_next = mfd_pkg::crc_byte(beat_i.frame_start ? mfd_pkg::CRC_INIT : crc_q, d_byte);
    date_w   = {date_hi_q, date_lo_q};

    pos_d      = pos_q;
    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    crc_hi_d   = crc_hi_q;
    id_d       = id_q;
    vol_d      = vol_q;
    date_lo_d  = date_lo_q;
    date_hi_d  = date_hi_q;

    res_valid_o = 1'b0;
    res_o       = '0;

    if (beat_i.frame_start) begin
      crc_hi_d  = '0;
      id_d      = '0;
      vol_d     = '0;
      date_lo_d = '0;
      date_hi_d = '0;
      if (d_byte != mfd_pkg::LEN_EXPECTED) begin
        in_frame_d   = 1'b0;
        pos_d        = '0;
        crc_d        = mfd_pkg::CRC_INIT;
        res_valid_o  = beat_i.valid;
        res_o.status = mfd_pkg::STATUS_LEN;
      end else begin
        crc_d      = crc_next;
        pos_d      = 5'd1;
        in_frame_d = 1'b1;
      end
    end else if (in_frame_q) begin
      if (pos_q == 5'd0 || pos_q >= mfd_pkg::POS_END) begin
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else if (pos_q <= mfd_pkg::POS_LAST_PAYLOAD) begin
        crc_d = crc_next;
        case (pos_q)
          5'd1:    id_d[7:0]    = p_byte;
          5'd2:    id_d[15:8]   = p_byte;
          5'd3:    id_d[23:16]  = p_byte;
          5'd4:    id_d[31:24]  = p_byte;
          5'd5:    vol_d[7:0]   = p_byte;
          5'd6:    vol_d[15:8]  = p_byte;
          5'd7:    vol_d[23:16] = p_byte;
          5'd8:    vol_d[27:24] = p_byte[3:0];
          5'd16:   date_lo_d    = p_byte;
          5'd17:   date_hi_d    = p_byte;
          default: ;
        endcase
        pos_d = pos_q + 5'd1;
      end else if (pos_q == mfd_pkg::POS_CRC_HI) begin
        crc_hi_d = d_byte;
        pos_d    = pos_q + 5'd1;
      end else begin
        in_frame_d  = 1'b0;
        pos_d       = '0;
        res_valid_o = beat_i.valid;
        if ({crc_hi_q, d_byte} != crc_q) begin
          res_o.status = mfd_pkg::STATUS_CRC;
        end else begin
          res_o.status        = mfd_pkg::STATUS_OK;
          res_o.device_id     = id_q ^ mfd_pkg::ID_XOR;
          res_o.volume_liters = vol_q[27:3];
          res_o.year_offset   = date_w[15:9];
          res_o.month_field   = date_w[8:5];
          res_o.day_field     = date_w[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      in_frame_q <= 1'b0;
      crc_q      <= mfd_pkg::CRC_INIT;
      crc_hi_q   <= '0;
      id_q       <= '0;
      vol_q      <= '0;
      date_lo_q  <= '0;
      date_hi_q  <= '0;
    end else if (en_i) begin
      pos_q      <= pos_d;
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      id_q       <= id_d;
      vol_q      <= vol_d;
      date_lo_q  <= date_lo_d;
      date_hi_q  <= date_hi_d;
    end
  end

endmodule

// ----- rtl/meter_frame_dewhiten_crc_decode_unit.sv -----
// Top level of the meter frame decoder: input register, frame core, result register.
// Depends on mfd_pkg, mfd_in_if, mfd_out_if and mfd_frame_core.
//
// Takes one byte beat per cycle unless a new result finds the result register full;
// the 22 frame bytes are flagged by frame_start on the length byte. A byte is held
// in the input register while the frame core dewhitens it, advances the CRC by a
// full byte and updates the field accumulators; a result (bad length at once,
// CRC/ok on the last byte) goes from the held byte into the result register.
// The byte-wide CRC step sets the cycle path. Input ready stays high while a
// result waits, until a second result would have to overwrite it.
module meter_frame_dewhiten_crc_decode_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  mfd_in_if.sink       in_i,
  mfd_out_if.source    out_o
);

  mfd_pkg::beat_t   stg_q;
  mfd_pkg::result_t res;
  mfd_pkg::result_t out_q;
  logic             out_valid_q;
  logic             res_valid;
  logic             stg_adv;

  mfd_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (stg_q),
    .en_i        (stg_adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign stg_adv    = stg_q.valid && (!res_valid || !out_valid_q || out_o.ready);
  assign in_i.ready = !stg_q.valid || stg_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else if (in_i.ready) begin
      stg_q.valid       <= in_i.valid;
      stg_q.frame_byte  <= in_i.frame_byte;
      stg_q.frame_start <= in_i.frame_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.device_id     = out_q.device_id;
  assign out_o.volume_liters = out_q.volume_liters;
  assign out_o.year_offset   = out_q.year_offset;
  assign out_o.month_field   = out_q.month_field;
  assign out_o.day_field     = out_q.day_field;

  // stalled beat stays put in the input register
  a_stg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_q.valid && !stg_adv |=> stg_q.valid && $stable(stg_q))
    else $error("input register lost a stalled beat");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");

  // error results carry zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != mfd_pkg::STATUS_OK |->
      out_q.device_id == '0 && out_q.volume_liters == '0 && out_q.year_offset == '0)
    else $error("error result with non-zero fields");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for meter_frame_dewhiten_crc_decode_unit.
// Byte beats go in through mfd_in_if and are predicted in the bench.
// Result beats come out through mfd_out_if and are checked field by field.
// Depends on mfd_pkg, mfd_in_if, mfd_out_if and the RTL top level.
module tb_top;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_FULL
  } fill_e;

  localparam logic [7:0] KEY_TABLE [22] = '{
    8'hff, 8'he1, 8'h1d, 8'h9a, 8'hed, 8'h85, 8'h33, 8'h24, 8'hea, 8'h7a, 8'hd2,
    8'h39, 8'h70, 8'h97, 8'h57, 8'h0a, 8'h54, 8'h7d, 8'h2d, 8'hd8, 8'h6d, 8'h0d
  };

  localparam logic [3:0] NIB_MAP [16] = '{
    4'h0, 4'h7, 4'hf, 4'h9, 4'he, 4'hd, 4'h3, 4'h4,
    4'h2, 4'h6, 4'hc, 4'hb, 4'h1, 4'h8, 4'ha, 4'h5
  };

  logic clk;
  logic rst_n;
  logic gaps_on;
  int   errors;
  int   bytes_sent;

  // decoder state as the bench sees it
  logic [4:0]  dec_pos;
  logic        dec_open;
  logic [15:0] dec_crc;
  logic [7:0]  dec_crc_hi;
  logic [31:0] dec_id;
  logic [31:0] dec_vol;
  logic [7:0]  dec_date_lo;
  logic [7:0]  dec_date_hi;

  mfd_pkg::result_t awaited_results [$];
  logic [7:0]       frame_buf [22];

  mfd_in_if  byte_ch ();
  mfd_out_if res_ch ();

  meter_frame_dewhiten_crc_decode_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    int k;
    r = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ mfd_pkg::CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  task automatic decode_frame_byte(input logic [7:0] raw, input logic start);
    logic [7:0] d;
    logic [7:0] p;
    logic [4:0] q;
    mfd_pkg::result_t r;
    r = '0;
    if (start) begin
      d = raw ^ KEY_TABLE[0];
      dec_crc_hi = '0;
      dec_id = '0;
      dec_vol = '0;
      dec_date_lo = '0;
      dec_date_hi = '0;
      if (d != mfd_pkg::LEN_EXPECTED) begin
        dec_open = 1'b0;
        dec_pos = '0;
        dec_crc = mfd_pkg::CRC_INIT;
        r.status = mfd_pkg::STATUS_LEN;
        awaited_results.push_back(r);
      end else begin
        dec_crc = crc16_step(mfd_pkg::CRC_INIT, d);
        dec_pos = 5'd1;
        dec_open = 1'b1;
      end
    end else if (dec_open) begin
      if (dec_pos == 5'd0 || dec_pos >= 5'(mfd_pkg::FRAME_BYTES)) begin
        dec_open = 1'b0;
        dec_pos = '0;
      end else begin
        d = raw ^ KEY_TABLE[dec_pos];
        if (dec_pos <= 5'd19) begin
          q = dec_pos - 5'd1;
          p = {NIB_MAP[d[7:4]], NIB_MAP[d[3:0]]};
          dec_crc = crc16_step(dec_crc, d);
          if (q < 5'd4)
            dec_id |= 32'(p) << (8 * q);
          else if (q < 5'd8)
            dec_vol |= 32'(p) << (8 * (q - 5'd4));
          else if (q == 5'd15)
            dec_date_lo = p;
          else if (q == 5'd16)
            dec_date_hi = p;
          dec_pos = dec_pos + 5'd1;
        end else if (dec_pos == 5'd20) begin
          dec_crc_hi = d;
          dec_pos = 5'd21;
        end else begin
          dec_open = 1'b0;
          dec_pos = '0;
          if ({dec_crc_hi, d} != dec_crc) begin
            r.status = mfd_pkg::STATUS_CRC;
          end else begin
            r.status = mfd_pkg::STATUS_OK;
            r.device_id = dec_id ^ mfd_pkg::ID_XOR;
            r.volume_liters = dec_vol[27:3];
            {r.year_offset, r.month_field, r.day_field} = {dec_date_hi, dec_date_lo};
          end
          awaited_results.push_back(r);
        end
      end
    end
  endtask

  // one beat; returns at the edge that took it
  task automatic send_byte(input logic [7:0] b, input logic start);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.frame_byte  <= b;
    byte_ch.frame_start <= start;
    do @(posedge clk); while (!byte_ch.ready);
    decode_frame_byte(b, start);
    bytes_sent++;
  endtask

  task automatic make_frame(input fill_e fill);
    logic [7:0]  d [22];
    logic [15:0] c;
    int i;
    d[0] = mfd_pkg::LEN_EXPECTED;
    for (i = 1; i <= 19; i++) begin
      case (fill)
        FILL_ZERO: d[i] = 8'h00;
        FILL_FULL: d[i] = 8'h22;
        default:   d[i] = 8'($urandom_range(0, 255));
      endcase
    end
    c = mfd_pkg::CRC_INIT;
    for (i = 0; i <= 19; i++) c = crc16_step(c, d[i]);
    d[20] = c[15:8];
    d[21] = c[7:0];
    for (i = 0; i < 22; i++) frame_buf[i] = d[i] ^ KEY_TABLE[i];
  endtask

  task automatic send_frame(input int n);
    int i;
    for (i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
  endtask

  task automatic pick_fill_and_make();
    case ($urandom_range(0, 9))
      0:       make_frame(FILL_ZERO);
      1:       make_frame(FILL_FULL);
      default: make_frame(FILL_RANDOM);
    endcase
  endtask

  task automatic test_stray_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  task automatic test_bad_length();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_full_scale_frame();
    make_frame(FILL_FULL);
    send_frame(mfd_pkg::FRAME_BYTES);
  endtask

  task automatic test_random_traffic();
    int kind;
    int idx;
    int n;
    while (bytes_sent < 410) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        pick_fill_and_make();
        send_frame(mfd_pkg::FRAME_BYTES);
      end else if (kind < 70) begin
        pick_fill_and_make();
        idx = $urandom_range(1, 21);
        frame_buf[idx][$urandom_range(0, 7)] ^= 1'b1;
        send_frame(mfd_pkg::FRAME_BYTES);
      end else if (kind < 82) begin
        // cut short; the next start abandons it
        pick_fill_and_make();
        send_frame($urandom_range(1, 21));
      end else if (kind < 92) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (5) begin
      pick_fill_and_make();
      if ($urandom_range(0, 3) == 0) frame_buf[$urandom_range(1, 21)] ^= 8'h10;
      send_frame(mfd_pkg::FRAME_BYTES);
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result sink: random stall bursts while gaps_on is set, checks every beat taken
  initial begin
    int stall;
    mfd_pkg::result_t w;
    stall = 0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, status %0d", $time, res_ch.status);
          errors++;
        end else begin
          w = awaited_results.pop_front();
          field_check("status", 32'(w.status), 32'(res_ch.status));
          field_check("device_id", w.device_id, res_ch.device_id);
          field_check("volume_liters", 32'(w.volume_liters), 32'(res_ch.volume_liters));
          field_check("year_offset", 32'(w.year_offset), 32'(res_ch.year_offset));
          field_check("month_field", 32'(w.month_field), 32'(res_ch.month_field));
          field_check("day_field", 32'(w.day_field), 32'(res_ch.day_field));
        end
      end
      if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 3) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    gaps_on = 1'b1;
    errors = 0;
    bytes_sent = 0;
    dec_pos = '0;
    dec_open = 1'b0;
    dec_crc = mfd_pkg::CRC_INIT;
    dec_crc_hi = '0;
    dec_id = '0;
    dec_vol = '0;
    dec_date_lo = '0;
    dec_date_hi = '0;
    byte_ch.valid = 1'b0;
    byte_ch.frame_byte = '0;
    byte_ch.frame_start = 1'b0;
    res_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_stray_bytes();
    test_bad_length();
    test_full_scale_frame();
    test_random_traffic();
    test_back_to_back();
    byte_ch.valid <= 1'b0;

    waited = 0;
    while (awaited_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      errors++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[meter_frame_dewhiten_crc_decode_unit] OK");
    end else begin
      $display("[meter_frame_dewhiten_crc_decode_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("[meter_frame_dewhiten_crc_decode_unit] ERROR");
    $finish;
  end

endmodule
